// ----- hw/rtl/bhc_pkg.sv -----
// Shared types and constants of the bucketed histogram counter.
package bhc_pkg;

  localparam int BIN_W       = 11;
  localparam int MAXV_W      = 11;
  localparam int BLEN_W      = 10;
  localparam int COUNT_OUT_W = 32;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [MAXV_W-1:0] MAXV_RESET = MAXV_W'(1024);
  localparam logic [BLEN_W-1:0] BLEN_RESET = BLEN_W'(16);

  localparam logic [CFG_IDX_W-1:0] REG_MAX_BIN       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_LENGTH = CFG_IDX_W'(1);

  localparam logic OP_INCR = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] count;
    logic                   bucket_touched;
    logic                   out_of_range;
  } result_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctrl_t;

  typedef struct packed {
    logic clearing;
  } mem_stat_t;

endpackage

// ----- hw/rtl/bhc_if.sv -----
// Handshake channels of the bucketed histogram counter: items, results, configuration.
interface bhc_item_if;
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [bhc_pkg::BIN_W-1:0] bin;

  modport source (output valid, output operation, output bin, input ready);
  modport sink (input valid, input operation, input bin, output ready);
endinterface

interface bhc_result_if;
  logic                          valid;
  logic                          ready;
  logic [bhc_pkg::COUNT_OUT_W-1:0] count;
  logic                          bucket_touched;
  logic                          out_of_range;

  modport source (output valid, output count, output bucket_touched, output out_of_range,
                  input ready);
  modport sink (input valid, input count, input bucket_touched, input out_of_range,
                output ready);
endinterface

interface bhc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bhc_pkg::CFG_IDX_W-1:0]  index;
  logic [bhc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/bhc_divider.sv -----
// Bit-serial restoring divider: bin slot over bucket length, one quotient bit per cycle.
module bhc_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bhc_pkg::BIN_W-1:0]   dividend_i,
  input  logic [bhc_pkg::BLEN_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [bhc_pkg::BIN_W-1:0]   quotient_o
);

  localparam int QW     = bhc_pkg::BIN_W;
  localparam int RW     = bhc_pkg::BLEN_W;
  localparam int STEP_W = $clog2(QW + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [QW-1:0]     quo_q, quo_d;
  logic [RW-1:0]     div_q, div_d;
  logic [RW:0]       trial;
  logic [RW:0]       diff;
  logic              fits;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    trial  = {rem_q, quo_q[QW-1]};
    diff   = trial - {1'b0, div_q};
    fits   = trial >= {1'b0, div_q};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[RW-1:0] : trial[RW-1:0];
      quo_d  = {quo_q[QW-2:0], fits};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      div_q  <= div_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hw/rtl/bhc_store.sv -----
// Bin counter and bucket touched memories with the clearing sweep after reset.
module bhc_store #(
  parameter int NUM_BINS    = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bhc_pkg::mem_ctrl_t           ctrl_i,
  input  logic [$clog2(NUM_BINS)-1:0]  slot_i,
  input  logic [$clog2(NUM_BINS)-1:0]  bucket_i,
  input  logic [COUNT_WIDTH-1:0]       wr_count_i,
  output logic [COUNT_WIDTH-1:0]       rd_count_o,
  output logic                         rd_touched_o,
  output bhc_pkg::mem_stat_t           stat_o
);

  localparam int IDX_W = $clog2(NUM_BINS);

  logic [COUNT_WIDTH-1:0] ctr_mem [NUM_BINS];
  logic                   tch_mem [NUM_BINS];

  logic                   clr_q, clr_d;
  logic [IDX_W-1:0]       clr_addr_q, clr_addr_d;
  logic                   we;
  logic [IDX_W-1:0]       ctr_addr;
  logic [IDX_W-1:0]       tch_addr;
  logic [COUNT_WIDTH-1:0] ctr_wdata;
  logic                   tch_wdata;
  logic [COUNT_WIDTH-1:0] rd_count_q;
  logic                   rd_touched_q;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + IDX_W'(1);
      if (clr_addr_q == IDX_W'(NUM_BINS - 1)) begin
        clr_d = 1'b0;
      end
    end
    we        = clr_q || ctrl_i.wr_en;
    ctr_addr  = clr_q ? clr_addr_q : slot_i;
    tch_addr  = clr_q ? clr_addr_q : bucket_i;
    ctr_wdata = clr_q ? '0 : wr_count_i;
    tch_wdata = !clr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      ctr_mem[ctr_addr] <= ctr_wdata;
      tch_mem[tch_addr] <= tch_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_count_q   <= ctr_mem[slot_i];
      rd_touched_q <= tch_mem[bucket_i];
    end
  end

  assign rd_count_o      = rd_count_q;
  assign rd_touched_o    = rd_touched_q;
  assign stat_o.clearing = clr_q;

endmodule

// ----- hw/rtl/bucketed_histogram_counter_core.sv -----
// Bucketed histogram counter top level: sequencer, configuration and result register.
// An accepted in-range item goes through the divider, the memory read and the response state to its result;
// a rejected bin goes through the error state. A new item is taken only when the sequencer is idle.
// The next item is taken while a result waits in the output register.
// Reset: a clearing sweep over all NUM_BINS entries of both memories with no item accepted;
// configuration writes are taken throughout.
module bucketed_histogram_counter_core #(
  parameter int NUM_BINS    = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bhc_cfg_if.sink          cfg_i,
  bhc_item_if.sink         in_i,
  bhc_result_if.source     out_o
);

  localparam int IDX_W      = $clog2(NUM_BINS);
  localparam int BIN_W      = bhc_pkg::BIN_W;
  localparam int BLEN_W     = bhc_pkg::BLEN_W;
  localparam int SLOT_EXT_W = (IDX_W > BIN_W) ? IDX_W : BIN_W;
  localparam int CNT_EXT_W  = (COUNT_WIDTH > bhc_pkg::COUNT_OUT_W) ? COUNT_WIDTH
                                                                    : bhc_pkg::COUNT_OUT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_RESP,
    ST_ERR
  } state_e;

  state_e                        state_q, state_d;
  logic                          out_valid_q, out_valid_d;
  bhc_pkg::result_t              res_q, res_d;
  logic                          op_q, op_d;
  logic [IDX_W-1:0]              slot_q, slot_d;
  logic [IDX_W-1:0]              bkt_q, bkt_d;
  logic [bhc_pkg::MAXV_W-1:0]    maxv_q;
  logic [BLEN_W-1:0]             blen_q;

  bhc_pkg::mem_ctrl_t            mem_ctrl;
  bhc_pkg::mem_stat_t            mem_stat;
  logic [COUNT_WIDTH-1:0]        rd_count;
  logic                          rd_touched;
  logic [COUNT_WIDTH-1:0]        new_count;
  logic [COUNT_WIDTH-1:0]        sel_count;
  logic [CNT_EXT_W-1:0]          count_ext;

  logic                          in_acc;
  logic                          out_free;
  logic                          bin_bad;
  logic [BIN_W-1:0]              slot_bin;
  logic [SLOT_EXT_W-1:0]         slot_ext;
  logic [SLOT_EXT_W-1:0]         quo_ext;
  logic [BLEN_W-1:0]             len;
  logic                          div_start;
  logic                          div_done;
  logic [BIN_W-1:0]              quotient;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxv_q <= bhc_pkg::MAXV_RESET;
      blen_q <= bhc_pkg::BLEN_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        bhc_pkg::REG_MAX_BIN:       maxv_q <= cfg_i.data[bhc_pkg::MAXV_W-1:0];
        bhc_pkg::REG_BUCKET_LENGTH: blen_q <= cfg_i.data[BLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE) && !mem_stat.clearing;

  always_comb begin
    in_acc    = in_i.valid && in_i.ready;
    out_free  = !out_valid_q || out_o.ready;
    bin_bad   = (in_i.bin > maxv_q) || (32'(in_i.bin) > 32'(NUM_BINS));
    slot_bin  = (in_i.bin == '0) ? '0 : in_i.bin - BIN_W'(1);
    slot_ext  = SLOT_EXT_W'(slot_bin);
    quo_ext   = SLOT_EXT_W'(quotient);
    len       = (blen_q == '0) ? BLEN_W'(1) : blen_q;
    div_start = in_acc && !bin_bad;
    new_count = rd_count + COUNT_WIDTH'(1);
    sel_count = (op_q == bhc_pkg::OP_INCR) ? new_count : rd_count;
    count_ext = CNT_EXT_W'(sel_count);

    state_d     = state_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    op_d        = op_q;
    slot_d      = slot_q;
    bkt_d       = bkt_q;
    mem_ctrl    = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d    = in_i.operation;
          slot_d  = slot_ext[IDX_W-1:0];
          state_d = bin_bad ? ST_ERR : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          bkt_d   = quo_ext[IDX_W-1:0];
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        mem_ctrl.rd_en = 1'b1;
        state_d        = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          mem_ctrl.wr_en       = (op_q == bhc_pkg::OP_INCR);
          res_d.count          = count_ext[bhc_pkg::COUNT_OUT_W-1:0];
          res_d.bucket_touched = (op_q == bhc_pkg::OP_INCR) ? 1'b1 : rd_touched;
          res_d.out_of_range   = 1'b0;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          res_d.count          = '0;
          res_d.bucket_touched = 1'b0;
          res_d.out_of_range   = 1'b1;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      op_q        <= bhc_pkg::OP_READ;
      slot_q      <= '0;
      bkt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
      op_q        <= op_d;
      slot_q      <= slot_d;
      bkt_q       <= bkt_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.count          = res_q.count;
  assign out_o.bucket_touched = res_q.bucket_touched;
  assign out_o.out_of_range   = res_q.out_of_range;

  bhc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (slot_bin),
    .divisor_i  (len),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  bhc_store #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (mem_ctrl),
    .slot_i       (slot_q),
    .bucket_i     (bkt_q),
    .wr_count_i   (new_count),
    .rd_count_o   (rd_count),
    .rd_touched_o (rd_touched),
    .stat_o       (mem_stat)
  );

endmodule
